### rtl/atdc_pkg.sv
// Shared types and constants for the averaged temperature damper control block.
// Used by the controller, datapath, top level and checker; depends on nothing.
package atdc_pkg;

    // Fixed field widths
    localparam int TEMP_W  = 16;
    localparam int BAND_W  = 3;
    localparam int LEVER_W = 16;
    localparam int DELTA_W = 17;
    localparam int STEPS_W = 14;
    localparam int SCALE_W = 16;

    // Volts-to-centi-degree scale: 3300 mV * 10 centi-degrees per mV
    localparam logic [SCALE_W-1:0] CENTI_SCALE = 16'd33000;

    // Register indexes (byte address / 4)
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_THR1  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_THR2  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_THR3  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_THR4  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_STEPS = 3'd4;

    localparam logic [TEMP_W-1:0]  THR1_RESET  = 16'd7500;
    localparam logic [TEMP_W-1:0]  THR2_RESET  = 16'd7700;
    localparam logic [TEMP_W-1:0]  THR3_RESET  = 16'd7900;
    localparam logic [TEMP_W-1:0]  THR4_RESET  = 16'd8000;
    localparam logic [STEPS_W-1:0] STEPS_RESET = 14'd1536;

    // Band codes
    localparam logic [BAND_W-1:0] BAND_0 = 3'd0;
    localparam logic [BAND_W-1:0] BAND_1 = 3'd1;
    localparam logic [BAND_W-1:0] BAND_2 = 3'd2;
    localparam logic [BAND_W-1:0] BAND_3 = 3'd3;
    localparam logic [BAND_W-1:0] BAND_4 = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_MUL,
        ST_DIV_INIT,
        ST_DIV,
        ST_DECIDE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic cap;
        logic acc;
        logic mul;
        logic div_init;
        logic div_step;
        logic decide;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } t_dp_sts;

    typedef struct packed {
        logic [TEMP_W-1:0]  thr1;
        logic [TEMP_W-1:0]  thr2;
        logic [TEMP_W-1:0]  thr3;
        logic [TEMP_W-1:0]  thr4;
        logic [STEPS_W-1:0] steps;
    } t_cfg;

endpackage

### rtl/averaged_temperature_damper_control_core.sv
// Top level of the averaged temperature damper control block: register file,
// controller and datapath. Depends on atdc_pkg, atdc_ctrl, atdc_datapath.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one converter code and the
//   adjust flag; a transaction completes when i_valid is high and o_stall low.
//   Output channel (o_valid / i_stall) carries one result per input item:
//   windowed mean in centi-degrees, band, lever target, signed step delta and
//   the moved flag.
//   An accepted item is accumulated, scaled, divided and banded, then loaded
//   into the output register. DIV_W = SUM_W + 16 - ADC_BITS is the dividend
//   width of the serial divider (22 at the defaults). One item is in flight at
//   a time; the serial divider by the fill count, one quotient bit per cycle,
//   bounds the rate at which new items are taken.
//   A finished result sits in the output register; the next item is taken
//   while it waits. If the receiver stalls, the result holds and the block
//   stops before loading the next one.
//   Reset (synchronous, active low) empties the sample window, zeroes the
//   sum and the lever position and restores the register defaults; no
//   clearing pass is needed. Registers sit at byte address 4*i on the APB
//   port and should be written only while the block is idle.
module averaged_temperature_damper_control_core #(
    parameter int WINDOW   = 60,
    parameter int ADC_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [ADC_BITS-1:0]                 i_adc_sample,
    input  logic                                i_adjust_enable,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [atdc_pkg::TEMP_W-1:0]         o_avg_temp_centi,
    output logic [atdc_pkg::BAND_W-1:0]         o_band,
    output logic [atdc_pkg::LEVER_W-1:0]        o_lever_target,
    output logic signed [atdc_pkg::DELTA_W-1:0] o_step_delta,
    output logic                                o_lever_moved,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [4:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    atdc_pkg::t_cfg    r_cfg;
    atdc_pkg::t_dp_cmd cmd;
    atdc_pkg::t_dp_sts sts;
    logic              ready;
    logic              cfg_wr;
    logic [atdc_pkg::REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thr1  <= atdc_pkg::THR1_RESET;
            r_cfg.thr2  <= atdc_pkg::THR2_RESET;
            r_cfg.thr3  <= atdc_pkg::THR3_RESET;
            r_cfg.thr4  <= atdc_pkg::THR4_RESET;
            r_cfg.steps <= atdc_pkg::STEPS_RESET;
        end else if (cfg_wr) begin
            case (reg_idx)
                atdc_pkg::REG_THR1:  r_cfg.thr1  <= pwdata[atdc_pkg::TEMP_W-1:0];
                atdc_pkg::REG_THR2:  r_cfg.thr2  <= pwdata[atdc_pkg::TEMP_W-1:0];
                atdc_pkg::REG_THR3:  r_cfg.thr3  <= pwdata[atdc_pkg::TEMP_W-1:0];
                atdc_pkg::REG_THR4:  r_cfg.thr4  <= pwdata[atdc_pkg::TEMP_W-1:0];
                atdc_pkg::REG_STEPS: r_cfg.steps <= pwdata[atdc_pkg::STEPS_W-1:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            atdc_pkg::REG_THR1:  prdata = 32'(r_cfg.thr1);
            atdc_pkg::REG_THR2:  prdata = 32'(r_cfg.thr2);
            atdc_pkg::REG_THR3:  prdata = 32'(r_cfg.thr3);
            atdc_pkg::REG_THR4:  prdata = 32'(r_cfg.thr4);
            atdc_pkg::REG_STEPS: prdata = 32'(r_cfg.steps);
            default:             prdata = '0;
        endcase
    end

    atdc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_ready (ready)
    );

    assign o_stall = !ready;

    atdc_datapath #(
        .WINDOW   (WINDOW),
        .ADC_BITS (ADC_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg            (r_cfg),
        .i_adc_sample     (i_adc_sample),
        .i_adjust_enable  (i_adjust_enable),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_avg_temp_centi (o_avg_temp_centi),
        .o_band           (o_band),
        .o_lever_target   (o_lever_target),
        .o_step_delta     (o_step_delta),
        .o_lever_moved    (o_lever_moved)
    );

endmodule

### rtl/atdc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module atdc_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 60,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/atdc_ctrl.sv
// Sequencing state machine for the damper control block.
// Depends on atdc_pkg for the state type and the command/status structs.
module atdc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  atdc_pkg::t_dp_sts  i_sts,
    output atdc_pkg::t_dp_cmd  o_cmd,
    output logic               o_ready
);

    atdc_pkg::t_state r_state;
    atdc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= atdc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            atdc_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = atdc_pkg::ST_ACC;
                end
            end
            atdc_pkg::ST_ACC:      n_state = atdc_pkg::ST_MUL;
            atdc_pkg::ST_MUL:      n_state = atdc_pkg::ST_DIV_INIT;
            atdc_pkg::ST_DIV_INIT: n_state = atdc_pkg::ST_DIV;
            atdc_pkg::ST_DIV: begin
                if (i_sts.div_last) begin
                    n_state = atdc_pkg::ST_DECIDE;
                end
            end
            atdc_pkg::ST_DECIDE:   n_state = atdc_pkg::ST_OUT;
            atdc_pkg::ST_OUT: begin
                if (i_sts.out_free) begin
                    n_state = atdc_pkg::ST_IDLE;
                end
            end
            default:               n_state = atdc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            atdc_pkg::ST_IDLE: begin
                o_ready   = 1'b1;
                o_cmd.cap = i_valid;
            end
            atdc_pkg::ST_ACC:      o_cmd.acc      = 1'b1;
            atdc_pkg::ST_MUL:      o_cmd.mul      = 1'b1;
            atdc_pkg::ST_DIV_INIT: o_cmd.div_init = 1'b1;
            atdc_pkg::ST_DIV:      o_cmd.div_step = 1'b1;
            atdc_pkg::ST_DECIDE:   o_cmd.decide   = 1'b1;
            atdc_pkg::ST_OUT:      o_cmd.load     = i_sts.out_free;
            default: begin
                o_cmd   = '0;
                o_ready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/atdc_datapath.sv
// Datapath: sample ring and running sum, scale multiply, serial divider by the
// fill count, band pick and lever tracking, output register. Uses atdc_pkg, atdc_ram.
module atdc_datapath #(
    parameter int WINDOW   = 60,
    parameter int ADC_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  atdc_pkg::t_dp_cmd                   i_cmd,
    output atdc_pkg::t_dp_sts                   o_sts,
    input  atdc_pkg::t_cfg                      i_cfg,
    input  logic [ADC_BITS-1:0]                 i_adc_sample,
    input  logic                                i_adjust_enable,
    input  logic                                i_stall,
    output logic                                o_valid,
    output logic [atdc_pkg::TEMP_W-1:0]         o_avg_temp_centi,
    output logic [atdc_pkg::BAND_W-1:0]         o_band,
    output logic [atdc_pkg::LEVER_W-1:0]        o_lever_target,
    output logic signed [atdc_pkg::DELTA_W-1:0] o_step_delta,
    output logic                                o_lever_moved
);

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = $clog2(WINDOW * ((2 ** ADC_BITS) - 1) + 1);
    localparam int PROD_W = SUM_W + atdc_pkg::SCALE_W;
    localparam int DIV_W  = PROD_W - ADC_BITS;
    localparam int CNT_W  = $clog2(DIV_W);
    localparam int TGT_W  = atdc_pkg::BAND_W + atdc_pkg::STEPS_W;

    logic [ADC_BITS-1:0] r_sample;
    logic                r_adjust;
    logic [SLOT_W-1:0]   r_slot;
    logic [FILL_W-1:0]   r_fill;
    logic [SUM_W-1:0]    r_sum;
    logic [PROD_W-1:0]   r_prod;
    logic [DIV_W-1:0]    r_dvd;
    logic [FILL_W-1:0]   r_rem;
    logic [CNT_W-1:0]    r_cnt;
    logic [atdc_pkg::LEVER_W-1:0] r_pos;

    logic [atdc_pkg::TEMP_W-1:0]         r_res_avg;
    logic [atdc_pkg::BAND_W-1:0]         r_res_band;
    logic [atdc_pkg::LEVER_W-1:0]        r_res_target;
    logic signed [atdc_pkg::DELTA_W-1:0] r_res_delta;
    logic                                r_res_moved;

    logic                                r_o_valid;
    logic [atdc_pkg::TEMP_W-1:0]         r_o_avg;
    logic [atdc_pkg::BAND_W-1:0]         r_o_band;
    logic [atdc_pkg::LEVER_W-1:0]        r_o_target;
    logic signed [atdc_pkg::DELTA_W-1:0] r_o_delta;
    logic                                r_o_moved;

    logic [ADC_BITS-1:0] ram_rdata;
    logic [ADC_BITS-1:0] old_sample;
    logic                window_full;

    atdc_ram #(
        .WIDTH (ADC_BITS),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.acc),
        .i_waddr (r_slot),
        .i_wdata (r_sample),
        .i_re    (i_cmd.cap),
        .i_raddr (r_slot),
        .o_rdata (ram_rdata)
    );

    // Until the window is full the outgoing sample counts as zero
    assign window_full = (r_fill == FILL_W'(WINDOW));
    assign old_sample  = window_full ? ram_rdata : '0;

    // Divider step: restoring, one quotient bit per cycle
    logic [FILL_W:0]   rem_sh;
    logic              rem_ge;
    logic [FILL_W:0]   rem_diff;
    logic [FILL_W-1:0] n_rem;

    assign rem_sh   = {r_rem, r_dvd[DIV_W-1]};
    assign rem_ge   = (rem_sh >= {1'b0, r_fill});
    assign rem_diff = rem_sh - {1'b0, r_fill};
    assign n_rem    = rem_ge ? rem_diff[FILL_W-1:0] : rem_sh[FILL_W-1:0];

    // Band pick and lever target
    logic [atdc_pkg::TEMP_W-1:0]         avg;
    logic [atdc_pkg::BAND_W-1:0]         band_pick;
    logic [TGT_W-1:0]                    target_full;
    logic [atdc_pkg::LEVER_W-1:0]        target;
    logic signed [atdc_pkg::DELTA_W-1:0] delta;

    assign avg = r_dvd[atdc_pkg::TEMP_W-1:0];

    always_comb begin
        if (avg < i_cfg.thr1) begin
            band_pick = atdc_pkg::BAND_0;
        end else if (avg < i_cfg.thr2) begin
            band_pick = atdc_pkg::BAND_1;
        end else if (avg < i_cfg.thr3) begin
            band_pick = atdc_pkg::BAND_2;
        end else if (avg < i_cfg.thr4) begin
            band_pick = atdc_pkg::BAND_3;
        end else begin
            band_pick = atdc_pkg::BAND_4;
        end
    end

    assign target_full = TGT_W'(band_pick) * TGT_W'(i_cfg.steps);
    assign target      = target_full[atdc_pkg::LEVER_W-1:0];
    assign delta       = $signed({1'b0, target}) - $signed({1'b0, r_pos});

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot    <= '0;
            r_fill    <= '0;
            r_sum     <= '0;
            r_pos     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.acc) begin
                r_sum <= r_sum - SUM_W'(old_sample) + SUM_W'(r_sample);
                if (r_slot == SLOT_W'(WINDOW - 1)) begin
                    r_slot <= '0;
                end else begin
                    r_slot <= r_slot + 1'b1;
                end
                if (!window_full) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (i_cmd.decide && r_adjust) begin
                r_pos <= target;
            end
            if (i_cmd.load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_sample <= i_adc_sample;
            r_adjust <= i_adjust_enable;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_sum) * PROD_W'(atdc_pkg::CENTI_SCALE);
        end
        if (i_cmd.div_init) begin
            // Divide by 2^ADC_BITS as a shift, then by the fill count
            r_dvd <= r_prod[PROD_W-1:ADC_BITS];
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[DIV_W-2:0], rem_ge};
            r_rem <= n_rem;
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.decide) begin
            r_res_avg <= avg;
            if (r_adjust) begin
                r_res_band   <= band_pick;
                r_res_target <= target;
                r_res_delta  <= delta;
                r_res_moved  <= (target != r_pos);
            end else begin
                r_res_band   <= atdc_pkg::BAND_0;
                r_res_target <= r_pos;
                r_res_delta  <= '0;
                r_res_moved  <= 1'b0;
            end
        end
        if (i_cmd.load) begin
            r_o_avg    <= r_res_avg;
            r_o_band   <= r_res_band;
            r_o_target <= r_res_target;
            r_o_delta  <= r_res_delta;
            r_o_moved  <= r_res_moved;
        end
    end

    assign o_sts.div_last = (r_cnt == CNT_W'(DIV_W - 1));
    assign o_sts.out_free = !r_o_valid || !i_stall;

    assign o_valid          = r_o_valid;
    assign o_avg_temp_centi = r_o_avg;
    assign o_band           = r_o_band;
    assign o_lever_target   = r_o_target;
    assign o_step_delta     = r_o_delta;
    assign o_lever_moved    = r_o_moved;

endmodule

### rtl/atdc_checker.sv
// Port-level checker for the damper control top level, with its bind.
// Depends on atdc_pkg for field widths.
module atdc_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_stall,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic [atdc_pkg::TEMP_W-1:0]         o_avg_temp_centi,
    input logic [atdc_pkg::BAND_W-1:0]         o_band,
    input logic [atdc_pkg::LEVER_W-1:0]        o_lever_target,
    input logic signed [atdc_pkg::DELTA_W-1:0] o_step_delta,
    input logic                                o_lever_moved
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_avg_temp_centi) && $stable(o_band)
            && $stable(o_lever_target) && $stable(o_step_delta) && $stable(o_lever_moved))
        else $error("stalled result changed");

    // Moved flag tracks a nonzero delta
    a_moved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_lever_moved == (o_step_delta != '0)))
        else $error("lever_moved disagrees with step_delta");

    // One item in flight: an accepted transaction makes the input busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken while an item is in flight");

    // Reset empties the output register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind averaged_temperature_damper_control_core atdc_checker u_atdc_checker (.*);
